@@ design/glcd_pkg.sv @@
// Shared types and constants of the graphic LCD text renderer.
// No dependencies; every other design file but glcd_ram imports this package.
package glcd_pkg;

  // Fixed field widths of the request, the transfer, the cursor and the column counter
  localparam int CHAR_W = 7;
  localparam int GCOL_W = 3;
  localparam int BYTE_W = 8;
  localparam int PAGE_W = 3;
  localparam int COL_W  = 8;
  localparam int IDX_W  = 4;

  // Request opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Character codes with special handling
  localparam logic [CHAR_W-1:0] CHAR_END     = 7'd0;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'd32;

  // Controller instruction bases
  localparam logic [BYTE_W-1:0] INSTR_PAGE = 8'hB8;
  localparam logic [BYTE_W-1:0] INSTR_COL  = 8'h40;

  // Reach of an all-blank glyph
  localparam logic [GCOL_W-1:0] SPACE_REACH = 3'd2;

  // Source of the byte put into the output register
  typedef enum logic [1:0] {
    EMIT_DATA_RAM  = 2'd0,
    EMIT_DATA_ZERO = 2'd1,
    EMIT_POS_PAGE  = 2'd2,
    EMIT_POS_COL   = 2'd3
  } emit_e;

  // Controller to datapath
  typedef struct packed {
    logic              font_wr;
    logic              font_rd;
    logic [GCOL_W-1:0] col;
    logic              load_char;
    logic [GCOL_W-1:0] reach;
    logic              emit;
    emit_e             kind;
    logic              last;
    logic              newline;
    logic              advance;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic rdata_nz;
    logic wrap;
    logic next_ge_half;
  } dp_sts_t;

endpackage

@@ design/glcd_in_if.sv @@
// Request channel of the renderer: valid/ready plus one load or render request.
// Depends on glcd_pkg for field widths.
interface glcd_in_if
  import glcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [CHAR_W-1:0] char_code;
  logic [GCOL_W-1:0] glyph_column;
  logic [BYTE_W-1:0] column_bits;

  modport source (output valid, output opcode, output char_code, output glyph_column,
                  output column_bits, input ready);
  modport sink   (input valid, input opcode, input char_code, input glyph_column,
                  input column_bits, output ready);
endinterface

@@ design/glcd_out_if.sv @@
// Transfer channel of the renderer: valid/ready plus one LCD bus transfer.
// Depends on glcd_pkg for field widths.
interface glcd_out_if
  import glcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              right_half;
  logic              is_data;
  logic [BYTE_W-1:0] bus_byte;
  logic              last;

  modport source (output valid, output right_half, output is_data, output bus_byte,
                  output last, input ready);
  modport sink   (input valid, input right_half, input is_data, input bus_byte,
                  input last, output ready);
endinterface

@@ design/glcd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module glcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 896
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ design/glcd_dp.sv @@
// Datapath of the renderer: font RAM, cursor registers and output register.
// Depends on glcd_pkg and glcd_ram; driven by glcd_ctrl commands.
module glcd_dp
  import glcd_pkg::*;
#(
  parameter int GLYPH_WIDTH = 7,
  parameter int NUM_CHARS   = 128,
  parameter int HALF_WIDTH  = 64,
  parameter int NUM_PAGES   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [CHAR_W-1:0] in_char_i,
  input  logic [GCOL_W-1:0] in_gcol_i,
  input  logic [BYTE_W-1:0] in_bits_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              out_right_half_o,
  output logic              out_is_data_o,
  output logic [BYTE_W-1:0] out_bus_byte_o,
  output logic              out_last_o
);
  localparam int DEPTH = NUM_CHARS * GLYPH_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  logic [CHAR_W-1:0] char_q;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              rsel_q, rsel_d;
  logic              out_valid_q;
  logic              out_rh_q;
  logic              out_data_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;

  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] rdata;
  logic [COL_W-1:0]  col_mod;
  logic [COL_W:0]    col_inc;
  logic [BYTE_W-1:0] emit_byte;

  // Font store
  assign waddr = AW'(int'(in_char_i) * GLYPH_WIDTH + int'(in_gcol_i));
  assign raddr = AW'(int'(char_q) * GLYPH_WIDTH + int'(cmd_i.col));

  glcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (cmd_i.font_wr),
    .waddr_i (waddr),
    .wdata_i (in_bits_i),
    .re_i    (cmd_i.font_rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Hold the character under render
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      char_q <= in_char_i;
    end
  end

  // Column within the current half
  always_comb begin
    if (col_q >= COL_W'(2 * HALF_WIDTH)) begin
      col_mod = col_q - COL_W'(2 * HALF_WIDTH);
    end else if (col_q >= COL_W'(HALF_WIDTH)) begin
      col_mod = col_q - COL_W'(HALF_WIDTH);
    end else begin
      col_mod = col_q;
    end
  end

  assign col_inc = {1'b0, col_q} + (COL_W+1)'(1);

  // Cursor: newline steps page, resets column and half; data write advances
  always_comb begin
    page_d = page_q;
    col_d  = col_q;
    rsel_d = rsel_q;
    if (cmd_i.newline) begin
      page_d = (page_q < PAGE_W'(NUM_PAGES - 1)) ? page_q + PAGE_W'(1) : '0;
      col_d  = '0;
      rsel_d = 1'b0;
    end else if (cmd_i.advance) begin
      col_d = col_inc[COL_W-1:0];
      if (col_inc >= (COL_W+1)'(HALF_WIDTH)) begin
        rsel_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      col_q  <= '0;
      rsel_q <= 1'b0;
    end else begin
      page_q <= page_d;
      col_q  <= col_d;
      rsel_q <= rsel_d;
    end
  end

  // Select the byte of the transfer
  always_comb begin
    case (cmd_i.kind)
      EMIT_DATA_RAM:  emit_byte = rdata;
      EMIT_DATA_ZERO: emit_byte = '0;
      EMIT_POS_PAGE:  emit_byte = INSTR_PAGE | BYTE_W'(page_q);
      EMIT_POS_COL:   emit_byte = INSTR_COL | col_mod;
      default:        emit_byte = '0;
    endcase
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_rh_q   <= rsel_q;
      out_data_q <= (cmd_i.kind == EMIT_DATA_RAM) || (cmd_i.kind == EMIT_DATA_ZERO);
      out_byte_q <= emit_byte;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_right_half_o = out_rh_q;
  assign out_is_data_o    = out_data_q;
  assign out_bus_byte_o   = out_byte_q;
  assign out_last_o       = out_last_q;

  // Status to the controller
  assign sts_o.out_free     = !out_valid_q || out_ready_i;
  assign sts_o.rdata_nz     = (rdata != '0);
  assign sts_o.wrap         = ({1'b0, col_q} + (COL_W+1)'(cmd_i.reach) + (COL_W+1)'(1))
                              > (COL_W+1)'(2 * HALF_WIDTH - 1);
  assign sts_o.next_ge_half = (col_inc >= (COL_W+1)'(HALF_WIDTH));
endmodule

@@ design/glcd_ctrl.sv @@
// Controller of the renderer: glyph scan, wrap decision and transfer sequencing.
// Depends on glcd_pkg; commands glcd_dp through dp_cmd_t and reads dp_sts_t.
module glcd_ctrl
  import glcd_pkg::*;
#(
  parameter int GLYPH_WIDTH = 7,
  parameter int NUM_CHARS   = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  input  logic [CHAR_W-1:0] in_char_i,
  input  logic [GCOL_W-1:0] in_gcol_i,
  output logic              in_ready_o,
  output dp_cmd_t           cmd_o,
  input  dp_sts_t           sts_i
);
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CHK = 3'd2;
  localparam logic [2:0] S_WRAP     = 3'd3;
  localparam logic [2:0] S_POS_PAGE = 3'd4;
  localparam logic [2:0] S_POS_COL  = 3'd5;
  localparam logic [2:0] S_COL_RD   = 3'd6;
  localparam logic [2:0] S_COL_EMIT = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [GCOL_W-1:0] scan_q, scan_d;
  logic              found_q, found_d;
  logic              space_q, space_d;
  logic              nl_q, nl_d;
  logic              pos_done_q, pos_done_d;
  logic              use_ram_q, use_ram_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  last_idx_q, last_idx_d;

  logic              accept;
  logic              in_range;
  logic [GCOL_W-1:0] reach;
  logic              final_wr;

  // Ready is high exactly in idle, so take the request from the state directly
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign in_range = (9'(in_char_i) < 9'(NUM_CHARS));
  assign final_wr = (k_q == last_idx_q);

  // Reach of the scanned glyph; the scan register holds its last nonblank column
  always_comb begin
    if (!found_q) begin
      reach = SPACE_REACH;
    end else if (scan_q == '0) begin
      reach = GCOL_W'(1);
    end else begin
      reach = scan_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    found_d    = found_q;
    space_d    = space_q;
    nl_d       = nl_q;
    pos_done_d = pos_done_q;
    use_ram_d  = use_ram_q;
    k_d        = k_q;
    last_idx_d = last_idx_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = EMIT_DATA_ZERO;
    cmd_o.reach = reach;

    unique case (state_q)
      // Take a request: store a load at once, start a render unless it is the string end
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_char = accept;
        if (accept) begin
          if (in_opcode_i == OP_LOAD) begin
            cmd_o.font_wr = in_range && (4'(in_gcol_i) < 4'(GLYPH_WIDTH));
          end else if (in_char_i != CHAR_END) begin
            space_d = (in_char_i == CHAR_SPACE);
            nl_d    = (in_char_i == CHAR_NEWLINE);
            found_d = 1'b0;
            scan_d  = GCOL_W'(GLYPH_WIDTH - 1);
            state_d = in_range ? S_SCAN_RD : S_WRAP;
          end
        end
      end
      // Scan glyph columns from the right for the last nonblank one
      S_SCAN_RD: begin
        cmd_o.font_rd = 1'b1;
        cmd_o.col     = scan_q;
        state_d       = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.rdata_nz) begin
          found_d = 1'b1;
          state_d = S_WRAP;
        end else if (scan_q == '0) begin
          state_d = S_WRAP;
        end else begin
          scan_d  = scan_q - GCOL_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      // Wrap to the next page if the glyph does not fit; handle newline
      S_WRAP: begin
        k_d        = '0;
        last_idx_d = found_q ? IDX_W'(reach) + IDX_W'(1) : IDX_W'(1);
        if (sts_i.wrap) begin
          cmd_o.newline = 1'b1;
          pos_done_d    = space_q || nl_q;
          state_d       = S_POS_PAGE;
        end else if (nl_q) begin
          cmd_o.newline = 1'b1;
          pos_done_d    = 1'b1;
          state_d       = S_POS_PAGE;
        end else begin
          state_d = S_COL_RD;
        end
      end
      // Send page and column on the current half
      S_POS_PAGE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EMIT_POS_PAGE;
          state_d    = S_POS_COL;
        end
      end
      S_POS_COL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EMIT_POS_COL;
          cmd_o.last = pos_done_q;
          state_d    = pos_done_q ? S_IDLE : S_COL_RD;
        end
      end
      // Fetch the glyph column, or use zero for spacer and blank columns
      S_COL_RD: begin
        use_ram_d     = found_q && !final_wr && (k_q < IDX_W'(GLYPH_WIDTH));
        cmd_o.font_rd = use_ram_d;
        cmd_o.col     = k_q[GCOL_W-1:0];
        state_d       = S_COL_EMIT;
      end
      // Write the column and advance; re-send position on the right half
      S_COL_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = use_ram_q ? EMIT_DATA_RAM : EMIT_DATA_ZERO;
          cmd_o.advance = 1'b1;
          cmd_o.last    = final_wr && !sts_i.next_ge_half;
          k_d           = k_q + IDX_W'(1);
          if (sts_i.next_ge_half) begin
            pos_done_d = final_wr;
            state_d    = S_POS_PAGE;
          end else begin
            state_d = final_wr ? S_IDLE : S_COL_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    found_q    <= found_d;
    space_q    <= space_d;
    nl_q       <= nl_d;
    pos_done_q <= pos_done_d;
    use_ram_q  <= use_ram_d;
    k_q        <= k_d;
    last_idx_q <= last_idx_d;
  end
endmodule

@@ design/glcd_proportional_text_renderer.sv @@
// Top level of the graphic LCD proportional text renderer.
// Depends on glcd_pkg, glcd_in_if, glcd_out_if, glcd_ctrl and glcd_dp.

// The block takes load and render requests and turns each rendered character
// into LCD bus transfers for a two-half display. A load request stores one
// glyph column in the font RAM; glyphs must be loaded before they are rendered.
// A render request first scans the glyph from its rightmost column back to its
// last nonblank column, with a RAM read and then a test for each column, and
// then makes the wrap decision. Each written column then takes a font RAM read
// and then a transfer, and each page or column instruction is one transfer.
// The block has a single font RAM read port and a one-deep output register.
// The next request is taken as soon as the final transfer of a character sits
// in the output register.
module glcd_proportional_text_renderer
  import glcd_pkg::*;
#(
  parameter int GLYPH_WIDTH = 7,
  parameter int NUM_CHARS   = 128,
  parameter int HALF_WIDTH  = 64,
  parameter int NUM_PAGES   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  glcd_in_if.sink    req_i,
  glcd_out_if.source cmd_o
);
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequence the render steps
  glcd_ctrl #(
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .NUM_CHARS   (NUM_CHARS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_opcode_i (req_i.opcode),
    .in_char_i   (req_i.char_code),
    .in_gcol_i   (req_i.glyph_column),
    .in_ready_o  (req_i.ready),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  // Hold font, cursor and output transfer
  glcd_dp #(
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .NUM_CHARS   (NUM_CHARS),
    .HALF_WIDTH  (HALF_WIDTH),
    .NUM_PAGES   (NUM_PAGES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .sts_o            (dp_sts),
    .in_char_i        (req_i.char_code),
    .in_gcol_i        (req_i.glyph_column),
    .in_bits_i        (req_i.column_bits),
    .out_ready_i      (cmd_o.ready),
    .out_valid_o      (cmd_o.valid),
    .out_right_half_o (cmd_o.right_half),
    .out_is_data_o    (cmd_o.is_data),
    .out_bus_byte_o   (cmd_o.bus_byte),
    .out_last_o       (cmd_o.last)
  );
endmodule

@@ design/glcd_chk.sv @@
// Port-level checker of the renderer, bound to the top level.
// Depends on glcd_pkg for constants; sees only the top-level ports.
module glcd_chk
  import glcd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              req_opcode_i,
  input logic [CHAR_W-1:0] req_char_i,
  input logic              cmd_valid_i,
  input logic              cmd_ready_i,
  input logic              cmd_is_data_i,
  input logic [BYTE_W-1:0] cmd_byte_i,
  input logic              cmd_last_i
);
  // A pending transfer holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && !cmd_ready_i |=> cmd_valid_i && $stable(cmd_byte_i) && $stable(cmd_last_i))
    else $error("transfer dropped or changed while stalled");

  // A load or string end adds no transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && !cmd_valid_i
      && ((req_opcode_i == OP_LOAD) || (req_char_i == CHAR_END)) |=> !cmd_valid_i)
    else $error("transfer caused by load or string end");

  // A taken render request is followed by ready low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_opcode_i == OP_RENDER) && (req_char_i != CHAR_END)
      |=> !req_ready_i)
    else $error("request taken during render");

  // No request is taken while a character still has transfers to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && !cmd_last_i |-> !req_ready_i)
    else $error("request taken before final transfer");

  // Instruction bytes are only page or column settings
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && !cmd_is_data_i |->
      (cmd_byte_i[7:6] == 2'b01) || (cmd_byte_i[7:3] == 5'b10111))
    else $error("malformed instruction byte");
endmodule

bind glcd_proportional_text_renderer glcd_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_opcode_i  (req_i.opcode),
  .req_char_i    (req_i.char_code),
  .cmd_valid_i   (cmd_o.valid),
  .cmd_ready_i   (cmd_o.ready),
  .cmd_is_data_i (cmd_o.is_data),
  .cmd_byte_i    (cmd_o.bus_byte),
  .cmd_last_i    (cmd_o.last)
);
